// ===== rtl/core/spi_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, the job word and queue status types and a sign-extension helper of the segment pair intersection core.
package spi_pkg;

	localparam int CW   = 16;             // coordinate bits
	localparam int FW   = 16;             // fraction bits of the result point
	localparam int IW   = 16;             // identifier bits
	localparam int XYW  = CW + FW;        // result coordinate bits
	localparam int DW   = CW + 1;         // coordinate difference bits
	localparam int PW   = 2 * DW;         // difference product bits
	localparam int NW   = PW + 1;         // cross product bits
	localparam int MAGW = NW - 1;         // cross product magnitude bits
	localparam int MW   = MAGW + CW;      // scaled numerator magnitude bits
	localparam int N2W  = MW + FW + 2;    // dividend bits with rounding offset
	localparam int D2W  = MAGW + 1;       // doubled divisor bits
	localparam int QW   = XYW;            // quotient bits kept

	typedef struct packed {
		logic                 hit;
		logic                 use_x;
		logic                 use_y;
		logic                 neg_x;
		logic                 neg_y;
		logic signed [CW-1:0] base_x;
		logic signed [CW-1:0] base_y;
		logic [MW-1:0]        mag_x;
		logic [MW-1:0]        mag_y;
		logic [MAGW-1:0]      den;
		logic [IW-1:0]        id_a;
		logic [IW-1:0]        id_b;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

endpackage

// ===== rtl/core/segment_pair_intersection.sv =====
`timescale 1ns / 1ps
// Top level of the segment pair intersection core.
//
// Usage: drive one segment pair (two segments by integer endpoints, plus an
// identifier for each) and raise start. The word is taken at a rising edge
// where start is high and busy is low. Every word yields exactly one result
// word: done pulses for one cycle with hit, cross_x/cross_y (signed Q16.16,
// zero on a miss) and both identifiers. The receiver cannot hold results off,
// so done is a plain strobe.
// Throughput: one word per cycle, sustained. Path from the accepting edge to
// the edge that takes the result: four front stages (classify, products,
// decide, scale), the job queue, one pipelined divider stage per quotient
// bit (32), and the result register. The divider depth sets the latency.
// The queue between front and back only fills if the back stalls, which it
// never does; busy reports a full queue and stays low in normal use.
// Reset (arst_n low) drops every word in flight and clears done and busy.
module segment_pair_intersection (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [spi_pkg::CW-1:0]  a_start_x,
	input  logic signed [spi_pkg::CW-1:0]  a_start_y,
	input  logic signed [spi_pkg::CW-1:0]  a_end_x,
	input  logic signed [spi_pkg::CW-1:0]  a_end_y,
	input  logic signed [spi_pkg::CW-1:0]  b_start_x,
	input  logic signed [spi_pkg::CW-1:0]  b_start_y,
	input  logic signed [spi_pkg::CW-1:0]  b_end_x,
	input  logic signed [spi_pkg::CW-1:0]  b_end_y,
	input  logic [spi_pkg::IW-1:0]         a_ident,
	input  logic [spi_pkg::IW-1:0]         b_ident,
	output logic                           done,
	output logic                           hit,
	output logic signed [spi_pkg::XYW-1:0] cross_x,
	output logic signed [spi_pkg::XYW-1:0] cross_y,
	output logic [spi_pkg::IW-1:0]         first_ident,
	output logic [spi_pkg::IW-1:0]         second_ident
);

	// accept-to-take latency in cycles
	localparam int LAT = spi_pkg::QW + 6;

	logic             take;
	logic             job_valid;
	spi_pkg::job_t    job;
	spi_pkg::job_t    pop_job;
	spi_pkg::q_stat_t qstat;
	logic             pop;

	// take a word only while the queue has room
	assign take = start & ~busy;
	assign busy = qstat.full;
	// the back end never stalls: drain the queue whenever it holds a word
	assign pop  = ~qstat.empty;

	spi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.a_ident   (a_ident),
		.b_ident   (b_ident),
		.job_valid (job_valid),
		.job       (job)
	);

	spi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid),
		.push_job (job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (qstat)
	);

	spi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pop),
		.in_job       (pop_job),
		.done         (done),
		.hit          (hit),
		.cross_x      (cross_x),
		.cross_y      (cross_y),
		.first_ident  (first_ident),
		.second_ident (second_ident)
	);

	// every accepted word comes out after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result word missing at expected latency");

	// a miss reports the origin
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (cross_x == '0 && cross_y == '0))
		else $error("miss with nonzero point");

endmodule

// ===== rtl/core/spi_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies a segment pair, forms cross products, decides the hit and forms scaled numerators.
module spi_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic signed [spi_pkg::CW-1:0] a_start_x,
	input  logic signed [spi_pkg::CW-1:0] a_start_y,
	input  logic signed [spi_pkg::CW-1:0] a_end_x,
	input  logic signed [spi_pkg::CW-1:0] a_end_y,
	input  logic signed [spi_pkg::CW-1:0] b_start_x,
	input  logic signed [spi_pkg::CW-1:0] b_start_y,
	input  logic signed [spi_pkg::CW-1:0] b_end_x,
	input  logic signed [spi_pkg::CW-1:0] b_end_y,
	input  logic [spi_pkg::IW-1:0]        a_ident,
	input  logic [spi_pkg::IW-1:0]        b_ident,
	output logic                          job_valid,
	output spi_pkg::job_t                 job
);

	typedef enum logic [1:0] {K_GEN, K_AVERT, K_BVERT, K_BOTH} kind_t;

	function automatic logic [spi_pkg::MAGW-1:0] absn(input logic signed [spi_pkg::NW-1:0] v);
		logic signed [spi_pkg::NW-1:0] t;
		t = v[spi_pkg::NW-1] ? -v : v;
		return t[spi_pkg::MAGW-1:0];
	endfunction

	function automatic logic [spi_pkg::CW-1:0] absq(input logic signed [spi_pkg::DW-1:0] v);
		logic signed [spi_pkg::DW-1:0] t;
		t = v[spi_pkg::DW-1] ? -v : v;
		return t[spi_pkg::CW-1:0];
	endfunction

	// ---- stage 1: differences, classification, operand selection
	logic signed [spi_pkg::DW-1:0] d1x, d1y, d2x, d2y, ex, ey;
	logic                          avert, bvert;
	kind_t                         kind;
	logic signed [spi_pkg::CW-1:0] vx, vy0, vy1, sx0, sx1, sy0, vlo, vhi, slo, shi;
	logic signed [spi_pkg::CW-1:0] bx_c, by_c;
	logic signed [spi_pkg::DW-1:0] sdx, sdy, dv, pv, wv, qy_c;
	logic                          sneg, span_ok, both_ok;
	logic signed [spi_pkg::DW-1:0] opa [6];
	logic signed [spi_pkg::DW-1:0] opb [6];

	assign d1x = spi_pkg::sx(a_end_x) - spi_pkg::sx(a_start_x);
	assign d1y = spi_pkg::sx(a_end_y) - spi_pkg::sx(a_start_y);
	assign d2x = spi_pkg::sx(b_end_x) - spi_pkg::sx(b_start_x);
	assign d2y = spi_pkg::sx(b_end_y) - spi_pkg::sx(b_start_y);
	assign ex  = spi_pkg::sx(b_start_x) - spi_pkg::sx(a_start_x);
	assign ey  = spi_pkg::sx(b_start_y) - spi_pkg::sx(a_start_y);
	assign avert = (a_start_x == a_end_x);
	assign bvert = (b_start_x == b_end_x);

	always_comb begin
		if (avert && bvert) begin
			kind = K_BOTH;
		end else if (avert) begin
			kind = K_AVERT;
		end else if (bvert) begin
			kind = K_BVERT;
		end else begin
			kind = K_GEN;
		end
	end

	always_comb begin
		if (kind == K_BVERT) begin
			vx = b_start_x; vy0 = b_start_y; vy1 = b_end_y;
			sx0 = a_start_x; sx1 = a_end_x; sy0 = a_start_y;
			sdx = d1x; sdy = d1y;
		end else begin
			vx = a_start_x; vy0 = a_start_y; vy1 = a_end_y;
			sx0 = b_start_x; sx1 = b_end_x; sy0 = b_start_y;
			sdx = d2x; sdy = d2y;
		end
	end

	assign sneg    = sdx[spi_pkg::DW-1];
	assign dv      = sneg ? -sdx : sdx;
	assign pv      = sneg ? -sdy : sdy;
	assign wv      = spi_pkg::sx(vx) - spi_pkg::sx(sx0);
	assign vlo     = (vy0 < vy1) ? vy0 : vy1;
	assign vhi     = (vy0 < vy1) ? vy1 : vy0;
	assign slo     = (sx0 < sx1) ? sx0 : sx1;
	assign shi     = (sx0 < sx1) ? sx1 : sx0;
	assign span_ok = (vx >= slo) && (vx <= shi);
	assign both_ok = (a_start_x == b_start_x) && (a_end_y == b_start_y);
	assign qy_c    = (kind == K_GEN) ? d1y : wv;

	always_comb begin
		case (kind)
			K_AVERT: begin bx_c = a_start_x; by_c = b_start_y; end
			K_BVERT: begin bx_c = b_start_x; by_c = a_start_y; end
			K_BOTH:  begin bx_c = a_start_x; by_c = a_end_y;   end
			default: begin bx_c = a_start_x; by_c = a_start_y; end
		endcase
	end

	always_comb begin
		if (kind == K_AVERT || kind == K_BVERT) begin
			opa[0] = pv;                                     opb[0] = wv;
			opa[1] = spi_pkg::sx(vlo) - spi_pkg::sx(sy0);    opb[1] = dv;
			opa[2] = spi_pkg::sx(vhi) - spi_pkg::sx(sy0);    opb[2] = dv;
			opa[3] = sdy;                                    opb[3] = dv;
			opa[4] = '0;                                     opb[4] = '0;
			opa[5] = '0;                                     opb[5] = '0;
		end else begin
			opa[0] = d1x; opb[0] = d2y;
			opa[1] = d1y; opb[1] = d2x;
			opa[2] = ex;  opb[2] = d2y;
			opa[3] = ey;  opb[3] = d2x;
			opa[4] = ex;  opb[4] = d1y;
			opa[5] = ey;  opb[5] = d1x;
		end
	end

	logic                          v_s1;
	kind_t                         kind_s1;
	logic signed [spi_pkg::DW-1:0] opa_s1 [6];
	logic signed [spi_pkg::DW-1:0] opb_s1 [6];
	logic                          span_s1, both_s1;
	logic signed [spi_pkg::DW-1:0] pv_s1, dv_s1, qx_s1, qy_s1;
	logic signed [spi_pkg::CW-1:0] bx_s1, by_s1;
	logic [spi_pkg::IW-1:0]        ida_s1, idb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		for (int k = 0; k < 6; k++) begin
			opa_s1[k] <= opa[k];
			opb_s1[k] <= opb[k];
		end
		span_s1 <= span_ok;
		both_s1 <= both_ok;
		pv_s1   <= pv;
		dv_s1   <= dv;
		qx_s1   <= d1x;
		qy_s1   <= qy_c;
		bx_s1   <= bx_c;
		by_s1   <= by_c;
		ida_s1  <= a_ident;
		idb_s1  <= b_ident;
	end

	// ---- stage 2: six products
	logic                          v_s2;
	kind_t                         kind_s2;
	logic signed [spi_pkg::PW-1:0] prod_s2 [6];
	logic                          span_s2, both_s2;
	logic signed [spi_pkg::DW-1:0] pv_s2, dv_s2, qx_s2, qy_s2;
	logic signed [spi_pkg::CW-1:0] bx_s2, by_s2;
	logic [spi_pkg::IW-1:0]        ida_s2, idb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		for (int k = 0; k < 6; k++) begin
			prod_s2[k] <= opa_s1[k] * opb_s1[k];
		end
		span_s2 <= span_s1;
		both_s2 <= both_s1;
		pv_s2   <= pv_s1;
		dv_s2   <= dv_s1;
		qx_s2   <= qx_s1;
		qy_s2   <= qy_s1;
		bx_s2   <= bx_s1;
		by_s2   <= by_s1;
		ida_s2  <= ida_s1;
		idb_s2  <= idb_s1;
	end

	// ---- stage 3: hit decision and division operands
	logic signed [spi_pkg::NW-1:0] den_r, tn_r, un_r, den_n, tn_n, un_n, px, py, dd;
	logic signed [spi_pkg::PW-1:0] cc, ee;
	logic                          gen_hit, vert_hit, hit_c;

	always_comb begin
		den_r = spi_pkg::NW'(prod_s2[0]) - spi_pkg::NW'(prod_s2[1]);
		tn_r  = spi_pkg::NW'(prod_s2[2]) - spi_pkg::NW'(prod_s2[3]);
		un_r  = spi_pkg::NW'(prod_s2[4]) - spi_pkg::NW'(prod_s2[5]);
		if (den_r[spi_pkg::NW-1]) begin
			den_n = -den_r;
			tn_n  = -tn_r;
			un_n  = -un_r;
		end else begin
			den_n = den_r;
			tn_n  = tn_r;
			un_n  = un_r;
		end
		gen_hit = (den_n != '0) && !tn_n[spi_pkg::NW-1] && (tn_n <= den_n)
			&& !un_n[spi_pkg::NW-1] && (un_n <= den_n);
		cc = prod_s2[3][spi_pkg::PW-1] ? prod_s2[3] : '0;
		ee = prod_s2[3][spi_pkg::PW-1] ? '0 : prod_s2[3];
		vert_hit = span_s2 && (prod_s2[1] <= prod_s2[0]) && (prod_s2[0] <= prod_s2[2])
			&& (cc <= prod_s2[0]) && (prod_s2[0] <= ee);
		case (kind_s2)
			K_GEN:   hit_c = gen_hit;
			K_BOTH:  hit_c = both_s2;
			default: hit_c = vert_hit;
		endcase
		px = tn_n;
		py = (kind_s2 == K_GEN) ? tn_n : spi_pkg::NW'(pv_s2);
		dd = (kind_s2 == K_GEN) ? den_n : spi_pkg::NW'(dv_s2);
	end

	logic                            v_s3, hit_s3, usex_s3, usey_s3, negx_s3, negy_s3;
	logic [spi_pkg::MAGW-1:0]        pmx_s3, pmy_s3, den_s3;
	logic [spi_pkg::CW-1:0]          qmx_s3, qmy_s3;
	logic signed [spi_pkg::CW-1:0]   bx_s3, by_s3;
	logic [spi_pkg::IW-1:0]          ida_s3, idb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		hit_s3  <= hit_c;
		usex_s3 <= (kind_s2 == K_GEN);
		usey_s3 <= (kind_s2 != K_BOTH);
		negx_s3 <= px[spi_pkg::NW-1] ^ qx_s2[spi_pkg::DW-1];
		negy_s3 <= py[spi_pkg::NW-1] ^ qy_s2[spi_pkg::DW-1];
		pmx_s3  <= absn(px);
		pmy_s3  <= absn(py);
		den_s3  <= dd[spi_pkg::MAGW-1:0];
		qmx_s3  <= absq(qx_s2);
		qmy_s3  <= absq(qy_s2);
		bx_s3   <= bx_s2;
		by_s3   <= by_s2;
		ida_s3  <= ida_s2;
		idb_s3  <= idb_s2;
	end

	// ---- stage 4: numerator magnitudes
	logic          v_s4;
	spi_pkg::job_t job_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		job_s4.hit    <= hit_s3;
		job_s4.use_x  <= usex_s3;
		job_s4.use_y  <= usey_s3;
		job_s4.neg_x  <= negx_s3;
		job_s4.neg_y  <= negy_s3;
		job_s4.base_x <= bx_s3;
		job_s4.base_y <= by_s3;
		job_s4.mag_x  <= pmx_s3 * qmx_s3;
		job_s4.mag_y  <= pmy_s3 * qmy_s3;
		job_s4.den    <= den_s3;
		job_s4.id_a   <= ida_s3;
		job_s4.id_b   <= idb_s3;
	end

	assign job_valid = v_s4;
	assign job       = job_s4;

endmodule

// ===== rtl/core/spi_queue.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the divider back end.
module spi_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  spi_pkg::job_t    push_job,
	input  logic             pop,
	output spi_pkg::job_t    pop_job,
	output spi_pkg::q_stat_t stat
);

	spi_pkg::job_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

	assign pop_job    = mem_q[rp_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("job queue underflow");

endmodule

// ===== rtl/core/spi_back.sv =====
`timescale 1ns / 1ps
// Back end: pipelined restoring divider, one quotient bit per stage, and result register.
module spi_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  spi_pkg::job_t                  in_job,
	output logic                           done,
	output logic                           hit,
	output logic signed [spi_pkg::XYW-1:0] cross_x,
	output logic signed [spi_pkg::XYW-1:0] cross_y,
	output logic [spi_pkg::IW-1:0]         first_ident,
	output logic [spi_pkg::IW-1:0]         second_ident
);

	typedef struct packed {
		logic                          hit;
		logic                          use_x;
		logic                          use_y;
		logic                          neg_x;
		logic                          neg_y;
		logic signed [spi_pkg::CW-1:0] base_x;
		logic signed [spi_pkg::CW-1:0] base_y;
		logic [spi_pkg::D2W-1:0]       div;
		logic [spi_pkg::D2W-1:0]       rem_x;
		logic [spi_pkg::D2W-1:0]       rem_y;
		logic [spi_pkg::QW-1:0]        dq_x;
		logic [spi_pkg::QW-1:0]        dq_y;
		logic [spi_pkg::IW-1:0]        id_a;
		logic [spi_pkg::IW-1:0]        id_b;
	} div_t;

	// one restoring step: remainder and dividend/quotient shift word
	function automatic logic [spi_pkg::D2W+spi_pkg::QW-1:0] step(
		input logic [spi_pkg::D2W-1:0] rem,
		input logic [spi_pkg::QW-1:0]  dq,
		input logic [spi_pkg::D2W-1:0] dv
	);
		logic [spi_pkg::D2W:0] r1;
		logic [spi_pkg::D2W:0] r2;
		logic                  ge;
		r1 = {rem, dq[spi_pkg::QW-1]};
		ge = (r1 >= {1'b0, dv});
		r2 = ge ? (r1 - {1'b0, dv}) : r1;
		return {r2[spi_pkg::D2W-1:0], dq[spi_pkg::QW-2:0], ge};
	endfunction

	// dividend = magnitude * 2^(FW+1) + rounding offset, divisor = 2 * den
	logic [spi_pkg::MAGW-1:0] cx, cy;
	logic [spi_pkg::N2W-1:0]  n2x, n2y;
	div_t                     head;

	always_comb begin
		cx  = in_job.neg_x ? (in_job.den - 1'b1) : in_job.den;
		cy  = in_job.neg_y ? (in_job.den - 1'b1) : in_job.den;
		n2x = {1'b0, in_job.mag_x, {(spi_pkg::FW+1){1'b0}}} + spi_pkg::N2W'(cx);
		n2y = {1'b0, in_job.mag_y, {(spi_pkg::FW+1){1'b0}}} + spi_pkg::N2W'(cy);
		head.hit    = in_job.hit;
		head.use_x  = in_job.use_x;
		head.use_y  = in_job.use_y;
		head.neg_x  = in_job.neg_x;
		head.neg_y  = in_job.neg_y;
		head.base_x = in_job.base_x;
		head.base_y = in_job.base_y;
		head.div    = {in_job.den, 1'b0};
		head.rem_x  = n2x[spi_pkg::QW+spi_pkg::D2W-1:spi_pkg::QW];
		head.rem_y  = n2y[spi_pkg::QW+spi_pkg::D2W-1:spi_pkg::QW];
		head.dq_x   = n2x[spi_pkg::QW-1:0];
		head.dq_y   = n2y[spi_pkg::QW-1:0];
		head.id_a   = in_job.id_a;
		head.id_b   = in_job.id_b;
	end

	div_t                   st_s [1:spi_pkg::QW];
	logic [spi_pkg::QW:1]   vld_s;
	div_t                   cur [spi_pkg::QW];
	div_t                   nxt [spi_pkg::QW];

	assign cur[0] = head;
	for (genvar k = 1; k < spi_pkg::QW; k++) begin : g_tap
		assign cur[k] = st_s[k];
	end

	always_comb begin
		for (int k = 0; k < spi_pkg::QW; k++) begin
			nxt[k] = cur[k];
			{nxt[k].rem_x, nxt[k].dq_x} = step(cur[k].rem_x, cur[k].dq_x, cur[k].div);
			{nxt[k].rem_y, nxt[k].dq_y} = step(cur[k].rem_y, cur[k].dq_y, cur[k].div);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[spi_pkg::QW-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < spi_pkg::QW; k++) begin
			st_s[k+1] <= nxt[k];
		end
	end

	// final point: base in fixed point plus signed rounded quotient
	div_t                    last;
	logic [spi_pkg::QW-1:0]  qx_v, qy_v;
	logic [spi_pkg::XYW-1:0] px_v, py_v;

	always_comb begin
		last = st_s[spi_pkg::QW];
		qx_v = last.use_x ? (last.neg_x ? -last.dq_x : last.dq_x) : '0;
		qy_v = last.use_y ? (last.neg_y ? -last.dq_y : last.dq_y) : '0;
		px_v = last.hit ? ({last.base_x, {spi_pkg::FW{1'b0}}} + qx_v) : '0;
		py_v = last.hit ? ({last.base_y, {spi_pkg::FW{1'b0}}} + qy_v) : '0;
	end

	logic                    done_q, hit_q;
	logic [spi_pkg::XYW-1:0] cx_q, cy_q;
	logic [spi_pkg::IW-1:0]  ida_q, idb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[spi_pkg::QW];
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= last.hit;
		cx_q  <= px_v;
		cy_q  <= py_v;
		ida_q <= last.id_a;
		idb_q <= last.id_b;
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign cross_x      = cx_q;
	assign cross_y      = cy_q;
	assign first_ident  = ida_q;
	assign second_ident = idb_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the segment pair intersection core: directed and random pairs.
module tb_top;

	// One segment pair as it goes into the core.
	typedef struct {
		logic signed [spi_pkg::CW-1:0] ax0, ay0, ax1, ay1;
		logic signed [spi_pkg::CW-1:0] bx0, by0, bx1, by1;
		logic [spi_pkg::IW-1:0]        ida, idb;
	} pair_t;

	// One result word as it comes out of the core.
	typedef struct {
		logic                           hit;
		logic signed [spi_pkg::XYW-1:0] qx, qy;
		logic [spi_pkg::IW-1:0]         ida, idb;
	} meet_t;

	// Scoreboard: predicts the meeting point of each accepted pair and
	// checks the result words against the oldest prediction.
	class meet_board;
		meet_t pending[$];
		int    errors = 0;

		// Round half up of p*q*2^FW/d for d > 0, done at 128 bits.
		static function longint round_quot(longint p, longint q, longint d);
			bit             neg;
			logic [127:0]   prod;
			logic [127:0]   quo;
			longint         mp, mq;
			neg  = (p < 0) != (q < 0);
			mp   = p < 0 ? -p : p;
			mq   = q < 0 ? -q : q;
			prod = 128'(mp) * 128'(mq);
			prod = (prod << (spi_pkg::FW + 1)) + 128'(neg ? d - 1 : d);
			quo  = prod / 128'(2 * d);
			return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
		endfunction

		static function bit in_span(longint v, longint e0, longint e1);
			longint lo, hi;
			lo = e0 < e1 ? e0 : e1;
			hi = e0 < e1 ? e1 : e0;
			return v >= lo && v <= hi;
		endfunction

		// Is y0 + num/d inside the span of e0 and e1?
		static function bit frac_within(longint y0, longint num, longint d,
			longint e0, longint e1);
			longint lo, hi;
			lo = e0 < e1 ? e0 : e1;
			hi = e0 < e1 ? e1 : e0;
			return (lo - y0) * d <= num && num <= (hi - y0) * d;
		endfunction

		// Vertical segment at vx against a sloped one; y of the meeting point in qy.
		static function bit upright_meet(longint vx, longint vy0, longint vy1,
			longint sx0, longint sy0, longint sx1, longint sy1, output longint qy);
			longint d, p, num;
			d  = sx1 - sx0;
			p  = sy1 - sy0;
			qy = 0;
			if (d < 0) begin
				d = -d;
				p = -p;
			end
			num = p * (vx - sx0);
			if (!in_span(vx, sx0, sx1) || !frac_within(sy0, num, d, vy0, vy1) ||
			    !frac_within(sy0, num, d, sy0, sy1))
				return 0;
			qy = sy0 * (longint'(1) << spi_pkg::FW) + round_quot(p, vx - sx0, d);
			return 1;
		endfunction

		static function meet_t locate(pair_t s);
			meet_t  r;
			longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, one, qx, qy;
			longint d1x, d1y, d2x, d2y, ex, ey, den, tn, un;
			bit     h;
			ax0 = s.ax0; ay0 = s.ay0; ax1 = s.ax1; ay1 = s.ay1;
			bx0 = s.bx0; by0 = s.by0; bx1 = s.bx1; by1 = s.by1;
			one = longint'(1) << spi_pkg::FW;
			qx  = 0;
			qy  = 0;
			h   = 0;
			if (ax0 == ax1 && bx0 == bx1) begin
				if (ax0 == bx0 && ay1 == by0) begin
					h  = 1;
					qx = ax0 * one;
					qy = ay1 * one;
				end
			end else if (ax0 == ax1) begin
				h  = upright_meet(ax0, ay0, ay1, bx0, by0, bx1, by1, qy);
				qx = ax0 * one;
			end else if (bx0 == bx1) begin
				h  = upright_meet(bx0, by0, by1, ax0, ay0, ax1, ay1, qy);
				qx = bx0 * one;
			end else begin
				d1x = ax1 - ax0; d1y = ay1 - ay0; d2x = bx1 - bx0; d2y = by1 - by0;
				ex  = bx0 - ax0; ey = by0 - ay0;
				den = d1x * d2y - d1y * d2x;
				tn  = ex * d2y - ey * d2x;
				un  = ex * d1y - ey * d1x;
				if (den < 0) begin
					den = -den;
					tn  = -tn;
					un  = -un;
				end
				if (den != 0 && tn >= 0 && tn <= den && un >= 0 && un <= den) begin
					h  = 1;
					qx = ax0 * one + round_quot(tn, d1x, den);
					qy = ay0 * one + round_quot(tn, d1y, den);
				end
			end
			r.hit = h;
			r.qx  = h ? qx[spi_pkg::XYW-1:0] : '0;
			r.qy  = h ? qy[spi_pkg::XYW-1:0] : '0;
			r.ida = s.ida;
			r.idb = s.idb;
			return r;
		endfunction

		function void note_pair(pair_t s);
			pending.push_back(locate(s));
		endfunction

		function void check_meet(meet_t got);
			meet_t want;
			if (pending.size() == 0) begin
				$error("result word with no pair outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				errors++;
			end
			if (got.qx !== want.qx) begin
				$error("cross_x: expected %h, got %h", want.qx, got.qx);
				errors++;
			end
			if (got.qy !== want.qy) begin
				$error("cross_y: expected %h, got %h", want.qy, got.qy);
				errors++;
			end
			if (got.ida !== want.ida) begin
				$error("first_ident: expected %h, got %h", want.ida, got.ida);
				errors++;
			end
			if (got.idb !== want.idb) begin
				$error("second_ident: expected %h, got %h", want.idb, got.idb);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000; // idle cycles before the watchdog trips

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           start = 0;
	logic                           busy;
	logic signed [spi_pkg::CW-1:0]  a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
	logic signed [spi_pkg::CW-1:0]  b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
	logic [spi_pkg::IW-1:0]         a_ident = '0, b_ident = '0;
	logic                           done;
	logic                           hit;
	logic signed [spi_pkg::XYW-1:0] cross_x, cross_y;
	logic [spi_pkg::IW-1:0]         first_ident, second_ident;

	meet_board board = new();
	int        quiet = 0;  // cycles since the last accepted word on either side

	segment_pair_intersection u_top (.*);

	always #2 clk = ~clk;

	// Check every result word on the edge that ends its strobe cycle.
	always @(posedge clk) begin
		meet_t got;
		if (done) begin
			got.hit = hit;
			got.qx  = cross_x;
			got.qy  = cross_y;
			got.ida = first_ident;
			got.idb = second_ident;
			board.check_meet(got);
		end
	end

	// Watchdog: trip when neither side moves a word for too long.
	always @(posedge clk) begin
		if (done || (start && !busy))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one pair, hold it until taken, then idle a random number of cycles.
	// With no idle the next pair follows at once and start stays high.
	task automatic send_pair(pair_t s);
		int gap;
		a_start_x <= s.ax0; a_start_y <= s.ay0; a_end_x <= s.ax1; a_end_y <= s.ay1;
		b_start_x <= s.bx0; b_start_y <= s.by0; b_end_x <= s.bx1; b_end_y <= s.by1;
		a_ident   <= s.ida; b_ident   <= s.idb;
		start     <= 1;
		do @(posedge clk); while (busy);
		board.note_pair(s);
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold until every predicted result word has come back.
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
		int bx0, int by0, int bx1, int by1);
		pair_t s;
		s.ax0 = spi_pkg::CW'(ax0); s.ay0 = spi_pkg::CW'(ay0);
		s.ax1 = spi_pkg::CW'(ax1); s.ay1 = spi_pkg::CW'(ay1);
		s.bx0 = spi_pkg::CW'(bx0); s.by0 = spi_pkg::CW'(by0);
		s.bx1 = spi_pkg::CW'(bx1); s.by1 = spi_pkg::CW'(by1);
		s.ida = spi_pkg::IW'($urandom);
		s.idb = spi_pkg::IW'($urandom);
		return s;
	endfunction

	// Random pair: full range, small box (frequent hits), or forced verticals.
	function automatic pair_t random_pair();
		pair_t s;
		int    span, mode;
		mode = $urandom_range(0, 9);
		span = (mode < 3) ? 32767 : ((mode < 6) ? 8 : 300);
		s = make_pair($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
			$urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
			$urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
			$urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
		if (mode == 0)
			s = make_pair($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		if (mode >= 6 && $urandom_range(0, 1)) s.ax1 = s.ax0;
		if (mode >= 6 && $urandom_range(0, 2) == 0) s.bx1 = s.bx0;
		// both vertical: often line them up end to start so they touch
		if (s.ax0 == s.ax1 && s.bx0 == s.bx1 && $urandom_range(0, 1)) begin
			s.bx0 = s.ax0;
			s.bx1 = s.ax0;
			s.by0 = s.ay1;
		end
		return s;
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: verticals, degenerate ends, parallel and collinear, extremes.
		send_pair(make_pair(5, 0, 5, 7, 5, 7, 5, 20));         // both vertical, touching
		send_pair(make_pair(5, 0, 5, 7, 5, 6, 5, 20));         // both vertical, overlap misses
		send_pair(make_pair(5, 0, 5, 7, 6, 7, 6, 20));         // both vertical, apart
		send_pair(make_pair(1, -5, 1, 5, 0, 0, 2, 1));         // A vertical, half step
		send_pair(make_pair(9, -5, 9, 5, 0, 0, 2, 1));         // A vertical, outside B's x
		send_pair(make_pair(0, 0, 3, 1, 2, -9, 2, 9));         // B vertical, thirds
		send_pair(make_pair(0, 0, 3, -1, 2, -9, 2, 9));        // B vertical, negative round
		send_pair(make_pair(4, 4, 4, 4, 0, 0, 8, 8));          // degenerate A on B
		send_pair(make_pair(0, 0, 4, 4, 0, 1, 4, 5));          // parallel
		send_pair(make_pair(0, 0, 4, 4, 2, 2, 6, 6));          // collinear overlap
		send_pair(make_pair(0, 0, 4, 4, 4, 4, 8, 0));          // touching at ends
		send_pair(make_pair(0, 0, 4, 4, 0, 4, 4, 0));          // plain crossing
		send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_pair(make_pair(-32768, 32767, 32767, -32767, -32767, -32768, 32766, 32767));
		send_pair(make_pair(-32768, -32768, -32768, 32767, -32768, 0, 32767, 1));
		send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_pair(make_pair(-1, -1, -1, -1, -1, -1, 0, 0));
		begin
			pair_t s;
			s = make_pair(0, 0, 1, 1, 1, 0, 0, 1);
			s.ida = '1; s.idb = '0;
			send_pair(s);
			s.ida = '0; s.idb = '1;
			send_pair(s);
		end

		// Let the pipe drain completely before the random part.
		start <= 0;
		drain();
		@(posedge clk);

		repeat (550) send_pair(random_pair());
		start <= 0;

		drain();
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/spi_pkg.sv
rtl/core/spi_front.sv
rtl/core/spi_queue.sv
rtl/core/spi_back.sv
rtl/core/segment_pair_intersection.sv
test/tb_top.sv
